/* rtl/i2p_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, character codes and precedence helpers for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NULL   = 8'h00;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNMATCH  = 2'd2;

  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_OPERAND,
    CLS_OPER,
    CLS_LPAREN,
    CLS_RPAREN
  } cls_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_expr;
    cls_e       cls;
  } cmd_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       last;
    logic [1:0] error_code;
  } res_t;

  // Precedence weight; zero for anything that is not an operator
  function automatic logic [1:0] weight_f(input logic [7:0] c);
    logic [1:0] w;
    w = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) w = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) w = 2'd2;
    if (c == CH_DOLLAR)                w = 2'd3;
    return w;
  endfunction

  // True when the stacked operator must leave before the incoming one
  function automatic logic outranks_f(input logic [7:0] top, input logic [7:0] cur);
    logic [1:0] wt;
    logic [1:0] wc;
    wt = weight_f(top);
    wc = weight_f(cur);
    if (wt == wc) return top != CH_DOLLAR;
    return wt > wc;
  endfunction

endpackage

/* rtl/i2p_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_fifo
// Small register queue used between the converter's stages.
// ----------------------------------------------------------------------------
module i2p_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == DEPTH_C);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/i2p_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_front
// Accepts infix characters, classifies them and queues commands for the
// stack engine. Skippable characters without the end flag are dropped here.
// ----------------------------------------------------------------------------
module i2p_front (
  input  logic          push_i,
  output logic          full_o,
  input  logic [7:0]    char_in_i,
  input  logic          end_of_expr_i,
  output logic          cmd_wr_o,
  output i2p_pkg::cmd_t cmd_o,
  input  logic          cmd_full_i
);
  import i2p_pkg::*;

  cls_e cls;
  logic accept;

  always_comb begin
    if (char_in_i inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_DOLLAR}) begin
      cls = CLS_OPER;
    end else if (char_in_i inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
      cls = CLS_OPERAND;
    end else if (char_in_i == CH_LPAREN) begin
      cls = CLS_LPAREN;
    end else if (char_in_i == CH_RPAREN) begin
      cls = CLS_RPAREN;
    end else begin
      cls = CLS_SKIP;
    end
  end

  assign full_o            = cmd_full_i;
  assign accept            = push_i && !cmd_full_i;
  // drop skipped characters unless they close the expression
  assign cmd_wr_o          = accept && ((cls != CLS_SKIP) || end_of_expr_i);
  assign cmd_o.ch          = char_in_i;
  assign cmd_o.end_of_expr = end_of_expr_i;
  assign cmd_o.cls         = cls;

endmodule

/* rtl/i2p_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_back
// Stack engine: executes one queued command at a time against the operator
// stack and writes postfix results to the result queue.
// ----------------------------------------------------------------------------
module i2p_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  i2p_pkg::cmd_t cmd_i,
  output logic          cmd_rd_o,
  output logic          res_wr_o,
  output i2p_pkg::res_t res_o,
  input  logic          res_full_i
);
  import i2p_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             stale_q, stale_d;
  res_t             hold_q, hold_d;
  logic             hold_vld_q, hold_vld_d;
  logic [7:0]       stack_mem [STACK_DEPTH];
  logic [7:0]       top_q;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic             go;
  logic             produce;
  res_t             prod;
  logic             stk_push, stk_pop, stk_drop;

  assign cnt_m1 = count_q - 1'b1;
  assign rd_idx = cnt_m1[IDX_W-1:0];
  assign wr_idx = count_q[IDX_W-1:0];
  // top of stack is only trusted once the read has caught up with the count
  assign go     = !stale_q && !res_full_i;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    count_d    = count_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    cmd_rd_o   = 1'b0;
    res_wr_o   = 1'b0;
    res_o      = hold_q;
    produce    = 1'b0;
    prod       = '{char_out: CH_NULL, char_valid: 1'b0, last: 1'b0, error_code: ERR_NONE};
    stk_push   = 1'b0;
    stk_pop    = 1'b0;
    stk_drop   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_rd_o = 1'b1;
          cmd_d    = cmd_i;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_d = cmd_q.end_of_expr ? S_FLUSH : S_FIN;
          case (cmd_q.cls)
            CLS_OPERAND: begin
              produce = 1'b1;
              prod    = '{char_out: cmd_q.ch, char_valid: 1'b1, last: 1'b0,
                          error_code: ERR_NONE};
            end
            CLS_OPER: begin
              if (count_q != '0 && top_q != CH_LPAREN && outranks_f(top_q, cmd_q.ch)) begin
                stk_pop = 1'b1;
                state_d = S_EXEC;
              end else if (count_q >= DEPTH_C) begin
                produce = 1'b1;
                prod.error_code = ERR_OVERFLOW;
              end else begin
                stk_push = 1'b1;
              end
            end
            CLS_LPAREN: begin
              if (count_q >= DEPTH_C) begin
                produce = 1'b1;
                prod.error_code = ERR_OVERFLOW;
              end else begin
                stk_push = 1'b1;
              end
            end
            CLS_RPAREN: begin
              if (count_q != '0 && top_q != CH_LPAREN) begin
                stk_pop = 1'b1;
                state_d = S_EXEC;
              end else if (count_q != '0) begin
                stk_drop = 1'b1;
              end else begin
                produce = 1'b1;
                prod.error_code = ERR_UNMATCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (go) begin
          if (count_q != '0) begin
            stk_pop = 1'b1;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!res_full_i) begin
          if (hold_vld_q) begin
            res_wr_o   = 1'b1;
            res_o.last = cmd_q.end_of_expr;
            hold_vld_d = 1'b0;
          end else if (cmd_q.end_of_expr) begin
            res_wr_o = 1'b1;
            res_o    = '{char_out: CH_NULL, char_valid: 1'b0, last: 1'b1,
                         error_code: ERR_NONE};
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (stk_pop) begin
      produce = 1'b1;
      prod    = '{char_out: top_q, char_valid: 1'b1, last: 1'b0, error_code: ERR_NONE};
    end
    if (stk_pop || stk_drop) begin
      count_d = count_q - 1'b1;
    end
    if (stk_push) begin
      count_d = count_q + 1'b1;
    end
    // hold one result back so the final one of an expression can be marked
    if (produce) begin
      if (hold_vld_q) begin
        res_wr_o = 1'b1;
      end
      hold_d     = prod;
      hold_vld_d = 1'b1;
    end
    stale_d = stk_push || stk_pop || stk_drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      stale_q    <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      stale_q    <= stale_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    hold_q <= hold_d;
  end

  always_ff @(posedge clk_i) begin
    if (stk_push) begin
      stack_mem[wr_idx] <= cmd_q.ch;
    end
    top_q <= stack_mem[rd_idx];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DEPTH_C)
    else $error("operator stack count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_wr_o |-> !res_full_i)
    else $error("result transfer into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_rd_o |-> !cmd_empty_i)
    else $error("command read from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (stk_pop || stk_drop) |-> (count_q != '0 && !stale_q))
    else $error("pop from an empty or unsettled stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q != $past(count_q)) |-> stale_q)
    else $error("stack count moved without a settle cycle");

endmodule

/* rtl/infix_to_postfix_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Streaming shunting-yard converter: infix characters in, postfix out.
// ----------------------------------------------------------------------------
// Input channel: present char_in_i/end_of_expr_i with push high; a transfer
// happens on a clock edge where push is high and full is low. Spaces, commas
// and other unknown characters are dropped at the front unless they carry the
// end flag.
// Result channel: while empty is low the oldest result sits on char_out_o,
// char_valid_o, last_o and error_code_o; pop high on an edge takes it.
// Processing: the stack engine handles one character at a time, plus a step for
// every operator popped to the output; the end flag adds an empty-stack check,
// after a wait when the character itself pushed or discarded a stack entry. The
// wait after each stack change covers the registered read of the stack memory.
// A command queue in front lets the sender run ahead meanwhile.
// Stall: when pop is held low the result queue fills, the engine waits, then
// the command queue fills and full rises. Nothing is lost.
// Reset: both queues and the stack are emptied; stack contents are not cleared.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       end_of_expr_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out_o,
  output logic       char_valid_o,
  output logic       last_o,
  output logic [1:0] error_code_o
);
  import i2p_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  logic             cmd_wr, cmd_full, cmd_empty, cmd_rd;
  cmd_t             cmd_in, cmd_out;
  logic [CMD_W-1:0] cmd_rdata;
  logic             res_wr, res_full;
  res_t             res_in, res_out;
  logic [RES_W-1:0] res_rdata;

  i2p_front u_front (
    .push_i        (push),
    .full_o        (full),
    .char_in_i     (char_in_i),
    .end_of_expr_i (end_of_expr_i),
    .cmd_wr_o      (cmd_wr),
    .cmd_o         (cmd_in),
    .cmd_full_i    (cmd_full)
  );

  i2p_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (4)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .rd_i    (cmd_rd),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_rdata);

  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_rd_o    (cmd_rd),
    .res_wr_o    (res_wr),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  i2p_fifo #(
    .WIDTH (RES_W),
    .DEPTH (4)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out      = res_t'(res_rdata);
  assign char_out_o   = res_out.char_out;
  assign char_valid_o = res_out.char_valid;
  assign last_o       = res_out.last;
  assign error_code_o = res_out.error_code;

endmodule
